### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is asserted.
`define GBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define GBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/gbp_pkg.sv
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types, constants and counter update for the gshare predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbp_pkg;

  localparam int MIN_INDEX_BITS = 9;
  localparam int CFG_W          = 4;
  localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd14;

  localparam int ADDR_FIELD_W = 32;
  localparam int IN_W         = ((ADDR_FIELD_W + 1 + 7) / 8) * 8;
  localparam int TAKEN_BIT    = ADDR_FIELD_W;
  localparam int TOTAL_W      = 32;

  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 2;

  localparam logic [1:0] CTR_STRONG_NT = 2'd0;
  localparam logic [1:0] CTR_WEAK_NT   = 2'd1;
  localparam logic [1:0] CTR_WEAK_T    = 2'd2;
  localparam logic [1:0] CTR_STRONG_T  = 2'd3;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } gbp_tbl_ctrl_t;

  function automatic logic [1:0] gbp_next_ctr(logic [1:0] c, logic taken);
    logic [1:0] n;
    case (c)
      CTR_STRONG_NT: n = taken ? CTR_WEAK_NT  : CTR_STRONG_NT;
      CTR_WEAK_NT:   n = taken ? CTR_STRONG_T : CTR_STRONG_NT;
      CTR_WEAK_T:    n = taken ? CTR_STRONG_T : CTR_STRONG_NT;
      default:       n = taken ? CTR_STRONG_T : CTR_WEAK_T;
    endcase
    return n;
  endfunction

endpackage

### rtl/gbp_counter_table.sv
// ----------------------------------------------------------------------------
// gbp_counter_table
// Counter memory with registered read and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbp_counter_table
  import gbp_pkg::*;
#(
  parameter int ADDR_W = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbp_tbl_ctrl_t     ctrl_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [1:0]        wr_data_i,
  output logic [1:0]        rd_data_o,
  output logic              busy_o
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [1:0]        mem [DEPTH];
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic [1:0]        rd_data_q;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [1:0]        wdata;

  assign we    = clr_busy_q | ctrl_i.wr_en;
  assign waddr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_busy_q ? CTR_STRONG_NT : wr_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == {ADDR_W{1'b1}}) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

### rtl/gbp_result_fifo.sv
// ----------------------------------------------------------------------------
// gbp_result_fifo
// Small result queue that decouples the update stage from the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbp_result_fifo
  import gbp_pkg::*;
#(
  parameter int WIDTH = 80
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [WIDTH-1:0]      data_i,
  input  logic                  pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  valid_o,
  output logic [FIFO_CNT_W-1:0] count_o
);

  logic [WIDTH-1:0]      buf_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_pop;

  assign do_pop = pop_i & (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = buf_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

endmodule

### rtl/gshare_branch_predictor_core.sv
// ----------------------------------------------------------------------------
// gshare_branch_predictor_core
// Gshare predictor over a table of 2-bit hysteresis counters.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | content
//  s_axis   | in        | s_axis_tvalid/tready   | branch address, outcome
//  m_axis   | out       | m_axis_tvalid/tready   | prediction, miss, index, totals
//  cfg      | in        | cfg_valid_i/cfg_ready_o| index width
//
//  One branch per cycle while no sweep runs and the result queue has room;
//  a result passes the update stage register and the result queue before m_axis.
//  The rate is set by the single read and single write port of the table;
//  a back-to-back update of the same entry is forwarded.
//  After reset the table is swept to zero, all 2**MAX_INDEX_BITS entries
//  (16384 by default), with s_axis_tready low.
//  A three-entry result queue holds results while m_axis stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module gshare_branch_predictor_core
  import gbp_pkg::*;
#(
  parameter int MAX_INDEX_BITS = 14
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              s_axis_tvalid,
  output logic                                              s_axis_tready,
  // branch_address[31:0], branch_taken[32], zero pad
  input  logic [IN_W-1:0]                                   s_axis_tdata,
  output logic                                              m_axis_tvalid,
  input  logic                                              m_axis_tready,
  // predicted_taken, mispredicted, table_index, total_branches,
  // total_mispredicts, zero pad
  output logic [((2 + MAX_INDEX_BITS + 2 * TOTAL_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input  logic                                              cfg_valid_i,
  output logic                                              cfg_ready_o,
  input  logic [CFG_W-1:0]                                  cfg_data_i
);

  localparam int MW    = MAX_INDEX_BITS;
  localparam int EW    = $clog2(MAX_INDEX_BITS + 1);
  localparam int RES_W = 2 + MW + 2 * TOTAL_W;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;
  localparam logic [FIFO_CNT_W:0] OCC_MAX = (FIFO_CNT_W + 1)'(FIFO_DEPTH);

  logic [CFG_W-1:0]      index_bits_q;
  logic [MW-1:0]         hist_q;
  logic [EW-1:0]         cfg_ext;
  logic [EW-1:0]         eff_bits;
  logic [MW-1:0]         mask;
  logic [MW-1:0]         idx;
  logic                  in_xfer;
  logic                  in_taken;
  logic                  tbl_busy;
  gbp_tbl_ctrl_t         tbl_ctrl;
  logic [1:0]            rd_ctr;

  logic                  s1_valid_q;
  logic [MW-1:0]         s1_idx_q;
  logic                  s1_taken_q;
  logic                  fwd_valid_q;
  logic [MW-1:0]         fwd_idx_q;
  logic [1:0]            fwd_ctr_q;
  logic [1:0]            cur_ctr;
  logic [1:0]            new_ctr;
  logic                  pred;
  logic                  miss;

  logic [TOTAL_W-1:0]    br_tot_q, br_tot_d;
  logic [TOTAL_W-1:0]    mis_tot_q, mis_tot_d;

  logic [RES_W-1:0]      res;
  logic [RES_W-1:0]      fifo_out;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   occupancy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q <= INDEX_BITS_RESET;
    end else if (cfg_valid_i) begin
      index_bits_q <= cfg_data_i;
    end
  end

  // clamp index width and form the table index
  always_comb begin
    cfg_ext = EW'(index_bits_q);
    if (cfg_ext < EW'(MIN_INDEX_BITS)) begin
      eff_bits = EW'(MIN_INDEX_BITS);
    end else if (cfg_ext > EW'(MAX_INDEX_BITS)) begin
      eff_bits = EW'(MAX_INDEX_BITS);
    end else begin
      eff_bits = cfg_ext;
    end
    mask = {MW{1'b1}} >> (EW'(MAX_INDEX_BITS) - eff_bits);
    idx  = (s_axis_tdata[MW-1:0] ^ hist_q) & mask;
  end

  assign in_taken      = s_axis_tdata[TAKEN_BIT];
  assign occupancy     = {1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, s1_valid_q};
  assign s_axis_tready = !tbl_busy && (occupancy < OCC_MAX);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (in_xfer) begin
      hist_q <= {hist_q[MW-2:0], in_taken};
    end
  end

  assign tbl_ctrl.rd_en = in_xfer;
  assign tbl_ctrl.wr_en = s1_valid_q;

  gbp_counter_table #(
    .ADDR_W (MW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (tbl_ctrl),
    .rd_addr_i (idx),
    .wr_addr_i (s1_idx_q),
    .wr_data_i (new_ctr),
    .rd_data_o (rd_ctr),
    .busy_o    (tbl_busy)
  );

  // update stage: forward the write of the previous cycle
  always_comb begin
    cur_ctr   = (fwd_valid_q && (fwd_idx_q == s1_idx_q)) ? fwd_ctr_q : rd_ctr;
    pred      = cur_ctr[1];
    miss      = pred ^ s1_taken_q;
    new_ctr   = gbp_next_ctr(cur_ctr, s1_taken_q);
    br_tot_d  = br_tot_q;
    mis_tot_d = mis_tot_q;
    if (s1_valid_q) begin
      if (br_tot_q != {TOTAL_W{1'b1}}) begin
        br_tot_d = br_tot_q + 1'b1;
      end
      if (miss && (mis_tot_q != {TOTAL_W{1'b1}})) begin
        mis_tot_d = mis_tot_q + 1'b1;
      end
    end
    res = {mis_tot_d, br_tot_d, s1_idx_q, miss, pred};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      br_tot_q    <= '0;
      mis_tot_q   <= '0;
    end else begin
      s1_valid_q  <= in_xfer;
      fwd_valid_q <= s1_valid_q;
      br_tot_q    <= br_tot_d;
      mis_tot_q   <= mis_tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_idx_q   <= idx;
      s1_taken_q <= in_taken;
    end
    fwd_idx_q <= s1_idx_q;
    fwd_ctr_q <= new_ctr;
  end

  gbp_result_fifo #(
    .WIDTH (RES_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_valid_q),
    .data_i  (res),
    .pop_i   (m_axis_tready),
    .data_o  (fifo_out),
    .valid_o (m_axis_tvalid),
    .count_o (fifo_count)
  );

  assign m_axis_tdata = OUT_W'(fifo_out);

  `GBP_ASSERT(a_no_xfer_in_sweep, clk_i, rst_ni, in_xfer |-> !tbl_busy, "transfer during table sweep")
  `GBP_ASSERT(a_queue_room, clk_i, rst_ni, occupancy <= OCC_MAX, "result queue overflow")
  `GBP_ASSERT(a_totals_order, clk_i, rst_ni, mis_tot_q <= br_tot_q, "mispredict total above branch total")
  `GBP_ASSERT_ALWAYS(a_sweep_quiet, clk_i, tbl_busy |-> !s1_valid_q, "table write during sweep")

endmodule
